[rtl/core/sfcr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfcr_pkg
// Shared types and constants of the SPI flash command responder.
// ----------------------------------------------------------------------------
package sfcr_pkg;

  localparam int FLASH_BYTES_DEF = 131072;
  localparam int ADDR_W          = 24;
  localparam int SIZE_W          = 18;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [ADDR_W:0]   addr_ext_t;
  typedef logic [SIZE_W-1:0] size_t;

  localparam size_t SIZE_RESET = size_t'(131072);

  localparam logic [1:0] OP_WRITE    = 2'd0;
  localparam logic [1:0] OP_READ     = 2'd1;
  localparam logic [1:0] OP_SELECT   = 2'd2;
  localparam logic [1:0] OP_DESELECT = 2'd3;

  localparam logic [7:0] CMD_FAST_READ = 8'h0B;
  localparam logic [7:0] CMD_IDENTIFY  = 8'h9F;
  localparam logic [7:0] CMD_STATUS    = 8'h05;
  localparam logic [7:0] CMD_WREN      = 8'h06;
  localparam logic [7:0] CMD_ERASE     = 8'hD8;
  localparam logic [7:0] CMD_PROGRAM   = 8'h02;

  localparam logic [7:0] ID_MFR        = 8'h20;
  localparam logic [7:0] ID_TYPE       = 8'h20;
  localparam logic [7:0] ID_CAPACITY   = 8'h15;
  localparam logic [7:0] STATUS_BYTE   = 8'h02;
  localparam logic [7:0] ERASED_BYTE   = 8'hFF;

  typedef enum logic [2:0] {
    PH_COMMAND = 3'd0,
    PH_SHIFT1  = 3'd1,
    PH_SHIFT2  = 3'd2,
    PH_SHIFT3  = 3'd3,
    PH_SHIFT4  = 3'd4,
    PH_SHIFT5  = 3'd5,
    PH_PROCESS = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    PUSH_NONE = 2'd0,
    PUSH_BYTE = 2'd1,
    PUSH_MEM  = 2'd2
  } push_t;

  typedef struct packed {
    push_t      push;
    logic [7:0] push_data;
    logic       bad;
    logic       oor;
  } act_t;

endpackage
`default_nettype wire

[rtl/core/sfcr_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfcr_if
// Valid/ready channels of the SPI flash command responder.
// ----------------------------------------------------------------------------
interface sfcr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;
  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface sfcr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        bad_command;
  logic        out_of_range;
  modport source (output valid, output read_data, output bad_command,
                  output out_of_range, input ready);
  modport sink   (input valid, input read_data, input bad_command,
                  input out_of_range, output ready);
endinterface

interface sfcr_cfg_if;
  logic        valid;
  logic        ready;
  logic [17:0] flash_size_used;
  modport source (output valid, output flash_size_used, input ready);
  modport sink   (input valid, input flash_size_used, output ready);
endinterface
`default_nettype wire

[rtl/core/sfcr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfcr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sfcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[rtl/core/sfcr_cmd.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfcr_cmd
// Command machine, address tracking, store access issue and erase sweep.
// ----------------------------------------------------------------------------
module sfcr_cmd #(
  parameter int FLASH_BYTES = sfcr_pkg::FLASH_BYTES_DEF,
  localparam int AW         = $clog2(FLASH_BYTES)
) (
  input  logic            clk,
  input  logic            rst_n,
  sfcr_in_if.sink         in_ch,
  sfcr_cfg_if.sink        cfg_ch,
  input  logic            s1_ready,
  output logic            s1_load,
  output sfcr_pkg::act_t  s1_act,
  output logic            mem_we,
  output logic [AW-1:0]   mem_waddr,
  output logic [7:0]      mem_wdata,
  output logic            mem_re,
  output logic [AW-1:0]   mem_raddr
);

  localparam sfcr_pkg::addr_ext_t FB_LIMIT = sfcr_pkg::addr_ext_t'(FLASH_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(FLASH_BYTES - 1);

  sfcr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic             sel_r, sel_nxt;
  sfcr_pkg::addr_t  shin_r, shin_nxt;
  sfcr_pkg::addr_t  addr_r, addr_nxt;
  sfcr_pkg::size_t  size_r;
  logic             clr_busy_r;
  logic [AW-1:0]    clr_addr_r;

  logic             accept;
  logic             run;
  logic             a_ok;
  logic             rd_req;
  logic             wr_req;
  sfcr_pkg::addr_t  a_run;
  sfcr_pkg::act_t   act;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !clr_busy_r && s1_ready;
  assign accept       = in_ch.valid && in_ch.ready;

  assign a_run = (phase_r == sfcr_pkg::PH_SHIFT4) ? shin_r : addr_r;
  assign a_ok  = ({1'b0, a_run} < sfcr_pkg::addr_ext_t'(size_r)) &&
                 ({1'b0, a_run} < FB_LIMIT);

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    sel_nxt   = sel_r;
    shin_nxt  = shin_r;
    addr_nxt  = addr_r;
    act       = '{push: sfcr_pkg::PUSH_NONE, push_data: 8'h00, bad: 1'b0, oor: 1'b0};
    run       = 1'b0;
    rd_req    = 1'b0;
    wr_req    = 1'b0;
    case (in_ch.op)
      sfcr_pkg::OP_WRITE: begin
        case (phase_r)
          sfcr_pkg::PH_COMMAND: begin
            cmd_nxt = in_ch.data_byte;
            if (in_ch.data_byte inside {sfcr_pkg::CMD_FAST_READ, sfcr_pkg::CMD_IDENTIFY,
                                        sfcr_pkg::CMD_STATUS, sfcr_pkg::CMD_WREN,
                                        sfcr_pkg::CMD_ERASE, sfcr_pkg::CMD_PROGRAM}) begin
              phase_nxt = sfcr_pkg::PH_SHIFT1;
            end else begin
              act.bad = 1'b1;
            end
          end
          sfcr_pkg::PH_SHIFT1: begin
            shin_nxt  = {shin_r[15:0], in_ch.data_byte};
            phase_nxt = sfcr_pkg::PH_SHIFT2;
            if (cmd_r == sfcr_pkg::CMD_IDENTIFY) begin
              act.push      = sfcr_pkg::PUSH_BYTE;
              act.push_data = sfcr_pkg::ID_MFR;
            end else if (cmd_r == sfcr_pkg::CMD_STATUS) begin
              act.push      = sfcr_pkg::PUSH_BYTE;
              act.push_data = sfcr_pkg::STATUS_BYTE;
            end
          end
          sfcr_pkg::PH_SHIFT2: begin
            shin_nxt  = {shin_r[15:0], in_ch.data_byte};
            phase_nxt = sfcr_pkg::PH_SHIFT3;
            if (cmd_r == sfcr_pkg::CMD_IDENTIFY) begin
              act.push      = sfcr_pkg::PUSH_BYTE;
              act.push_data = sfcr_pkg::ID_TYPE;
            end
          end
          sfcr_pkg::PH_SHIFT3: begin
            shin_nxt  = {shin_r[15:0], in_ch.data_byte};
            phase_nxt = sfcr_pkg::PH_SHIFT4;
            if (cmd_r == sfcr_pkg::CMD_IDENTIFY) begin
              act.push      = sfcr_pkg::PUSH_BYTE;
              act.push_data = sfcr_pkg::ID_CAPACITY;
            end
          end
          sfcr_pkg::PH_SHIFT4: begin
            addr_nxt = shin_r;
            shin_nxt = {shin_r[15:0], in_ch.data_byte};
            if (cmd_r == sfcr_pkg::CMD_FAST_READ) begin
              phase_nxt = sfcr_pkg::PH_SHIFT5;
            end else begin
              phase_nxt = sfcr_pkg::PH_PROCESS;
              run       = 1'b1;
            end
          end
          default: begin
            phase_nxt = sfcr_pkg::PH_PROCESS;
            run       = 1'b1;
          end
        endcase
        if (run) begin
          case (cmd_r)
            sfcr_pkg::CMD_FAST_READ: begin
              addr_nxt = a_run + 1'b1;
              if (a_ok) begin
                rd_req   = 1'b1;
                act.push = sfcr_pkg::PUSH_MEM;
              end else begin
                act.push = sfcr_pkg::PUSH_BYTE;
                act.oor  = 1'b1;
              end
            end
            sfcr_pkg::CMD_ERASE: begin
              phase_nxt = sfcr_pkg::PH_COMMAND;
            end
            sfcr_pkg::CMD_PROGRAM: begin
              addr_nxt = a_run + 1'b1;
              wr_req   = a_ok;
              act.oor  = !a_ok;
            end
            default: begin
            end
          endcase
        end
      end
      sfcr_pkg::OP_SELECT: begin
        if (!sel_r) begin
          phase_nxt = sfcr_pkg::PH_COMMAND;
        end
        sel_nxt = 1'b1;
      end
      sfcr_pkg::OP_DESELECT: begin
        phase_nxt = sfcr_pkg::PH_COMMAND;
        sel_nxt   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= sfcr_pkg::PH_COMMAND;
      cmd_r      <= 8'h00;
      sel_r      <= 1'b0;
      shin_r     <= '0;
      addr_r     <= '0;
      size_r     <= sfcr_pkg::SIZE_RESET;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        cmd_r   <= cmd_nxt;
        sel_r   <= sel_nxt;
        shin_r  <= shin_nxt;
        addr_r  <= addr_nxt;
      end
      if (cfg_ch.valid) begin
        size_r <= cfg_ch.flash_size_used;
      end
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == CLR_LAST) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  assign s1_load   = accept;
  assign s1_act    = act;
  assign mem_we    = clr_busy_r || (accept && wr_req);
  assign mem_waddr = clr_busy_r ? clr_addr_r : a_run[AW-1:0];
  assign mem_wdata = clr_busy_r ? sfcr_pkg::ERASED_BYTE : in_ch.data_byte;
  assign mem_re    = accept && rd_req;
  assign mem_raddr = a_run[AW-1:0];

endmodule
`default_nettype wire

[rtl/core/sfcr_out.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfcr_out
// Shift-out register update from store data and result output register.
// ----------------------------------------------------------------------------
module sfcr_out (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           s1_load,
  input  sfcr_pkg::act_t s1_act,
  input  logic [7:0]     mem_rdata,
  output logic           s1_ready,
  sfcr_out_if.source     out_ch
);

  logic           s1_valid_r;
  sfcr_pkg::act_t act_r;
  logic [31:0]    shout_r, shout_nxt;
  logic           out_valid_r;
  logic [31:0]    read_data_r;
  logic           bad_r;
  logic           oor_r;
  logic           advance;

  assign advance  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign s1_ready = !s1_valid_r || advance;

  always_comb begin
    case (act_r.push)
      sfcr_pkg::PUSH_BYTE: shout_nxt = {shout_r[23:0], act_r.push_data};
      sfcr_pkg::PUSH_MEM:  shout_nxt = {shout_r[23:0], mem_rdata};
      default:             shout_nxt = shout_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      shout_r     <= '0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        shout_r     <= shout_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      act_r <= s1_act;
    end
    if (advance) begin
      read_data_r <= shout_nxt;
      bad_r       <= act_r.bad;
      oor_r       <= act_r.oor;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = read_data_r;
  assign out_ch.bad_command  = bad_r;
  assign out_ch.out_of_range = oor_r;

endmodule
`default_nettype wire

[rtl/core/spi_flash_command_responder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spi_flash_command_responder
// Device side of a byte-wide SPI NOR flash driven by bus transactions.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while no erase sweep runs and the output
// is not stalled, and returns its result through the shift-out stage and the
// output register, which lets the next transaction enter while a result waits.
// The flash image sits in one RAM with one write and one registered read port:
// a program writes it at acceptance, a fast read reads it at acceptance and the
// byte is merged into the shift-out register in the following stage. After
// reset an erase sweep writes 0xFF into every entry, one per cycle, holding off
// the input channel until it ends; configuration writes are taken throughout.
module spi_flash_command_responder #(
  parameter int FLASH_BYTES = sfcr_pkg::FLASH_BYTES_DEF,
  localparam int AW         = $clog2(FLASH_BYTES)
) (
  input  logic       clk,
  input  logic       rst_n,
  sfcr_in_if.sink    in_ch,
  sfcr_out_if.source out_ch,
  sfcr_cfg_if.sink   cfg_ch
);

  logic           s1_ready;
  logic           s1_load;
  sfcr_pkg::act_t s1_act;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  logic [7:0]     mem_rdata;

  sfcr_cmd #(
    .FLASH_BYTES (FLASH_BYTES)
  ) u_cmd (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .s1_ready  (s1_ready),
    .s1_load   (s1_load),
    .s1_act    (s1_act),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr)
  );

  sfcr_ram #(
    .WIDTH (8),
    .DEPTH (FLASH_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sfcr_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_load   (s1_load),
    .s1_act    (s1_act),
    .mem_rdata (mem_rdata),
    .s1_ready  (s1_ready),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

[rtl/core/sfcr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfcr_checker
// Port-level checks of the SPI flash command responder.
// ----------------------------------------------------------------------------
module sfcr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_read_data,
  input logic        out_bad_command,
  input logic        out_of_range
);

  // erase sweep holds off input right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during erase sweep");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data))
    else $error("stalled result changed");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_bad_command && out_of_range))
    else $error("bad command and out of range together");

  // an idle output wakes only for an accepted transaction
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching transaction");

endmodule

bind spi_flash_command_responder sfcr_checker u_sfcr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_read_data   (out_ch.read_data),
  .out_bad_command (out_ch.bad_command),
  .out_of_range    (out_ch.out_of_range)
);
`default_nettype wire
